// File: sv/rdvc_pkg.sv
// ----------------------------------------------------------------------------
// rdvc_pkg
// Shared widths, codes and sequencer states for the range dip classifier.
// ----------------------------------------------------------------------------
package rdvc_pkg;

    localparam int DIST_W           = 16;
    localparam int TIME_W           = 32;
    localparam int CAL_W            = 10;
    localparam int OFFSET_W         = 16;
    localparam int LIMIT_W          = 32;
    localparam int CFG_DATA_W       = 32;
    localparam int CFG_IDX_W        = 2;

    localparam int DIP_BUFFER_DEPTH = 256;
    localparam int DIP_CNT_W        = $clog2(DIP_BUFFER_DEPTH + 1);

    // calibration sum holds up to 2^CAL_W samples
    localparam int CSUM_W           = DIST_W + CAL_W;
    localparam int SUM_W            = DIST_W + DIP_CNT_W;
    localparam int SQ_W             = 2 * DIST_W + DIP_CNT_W;

    // serial multiplier: products n*Q, S*S and limit*n*n all fit here
    localparam int MUL_W            = 2 * DIST_W + 2 * DIP_CNT_W;
    localparam int MUL_B_W          = SUM_W;

    localparam int DIV_STEPS        = CSUM_W;
    localparam int DIV_CNT_W        = $clog2(DIV_STEPS + 1);

    localparam logic [CAL_W-1:0]    CALIB_COUNT_RST = CAL_W'(64);
    localparam logic [OFFSET_W-1:0] DIP_OFFSET_RST  = OFFSET_W'(160);
    localparam logic [TIME_W-1:0]   MIN_DUR_RST     = TIME_W'(500);
    localparam logic [LIMIT_W-1:0]  VAR_LIMIT_RST   = LIMIT_W'(2560);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CALIB_COUNT = 2'd0,
        CFG_DIP_OFFSET  = 2'd1,
        CFG_MIN_DUR     = 2'd2,
        CFG_VAR_LIMIT   = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        VERDICT_NONE        = 2'd0,
        VERDICT_VEHICLE     = 2'd1,
        VERDICT_OTHER       = 2'd2,
        VERDICT_CALIBRATING = 2'd3
    } verdict_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_SQ,
        ST_NQ,
        ST_SS,
        ST_LN,
        ST_LNN,
        ST_DONE
    } state_t;

endpackage

// File: sv/range_dip_variance_classifier.sv
// ----------------------------------------------------------------------------
// range_dip_variance_classifier
// Baseline calibration, dip tracking and variance classification of range
// samples, built around a shared bit-serial multiplier and divider.
// ----------------------------------------------------------------------------
//
//  channel | signals                               | direction
//  --------+---------------------------------------+-----------
//  input   | in_valid, in_ready, distance, time_ms | sink
//  output  | out_valid, out_ready, verdict         | source
//  config  | cfg_valid, cfg_ready, cfg_index,      | sink
//          | cfg_data                              |
//
//  One transaction at a time runs through the sequencer; in_ready is high
//  only while it is idle. Work per sample, from input accept to result load:
//    calibration sample: accumulate; last calibration sample: 26-step divide;
//    dip sample: 16-bit square of the sample; other samples: no serial work;
//    end of dip: four serial products, one bit per cycle.
//  The serial multiplier works on one significant bit of its second operand
//  per cycle and stops once the remaining bits are zero.
//  A finished verdict waits in the output register; the next sample is
//  taken meanwhile and stalls at its own end only if that register is full.
//  Reset is asynchronous, active low; registers return to their reset
//  values and no clearing pass is needed. cfg_ready is always high.
//
module range_dip_variance_classifier
    import rdvc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DIST_W-1:0]     distance,
    input  logic [TIME_W-1:0]     time_ms,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            verdict,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration
    logic [CAL_W-1:0]    calib_count_reg;
    logic [OFFSET_W-1:0] dip_offset_reg;
    logic [TIME_W-1:0]   min_dur_reg;
    logic [LIMIT_W-1:0]  var_limit_reg;

    // sequencer
    state_t state_reg;
    state_t state_next;

    // calibration state
    logic              calibrated_reg;
    logic [CSUM_W-1:0] calib_sum_reg;
    logic [CSUM_W-1:0] calib_sum_next;
    logic [CAL_W-1:0]  calib_seen_reg;
    logic [CAL_W-1:0]  calib_seen_next;
    logic [DIST_W-1:0] baseline_reg;

    // dip state: count, running sum and sum of squares
    logic                 dip_active_reg;
    logic [DIP_CNT_W-1:0] dip_samples_reg;
    logic [TIME_W-1:0]    dip_start_reg;
    logic [SUM_W-1:0]     dip_sum_reg;
    logic [SQ_W-1:0]      dip_sq_reg;

    // current sample and working values
    logic [DIST_W-1:0] d_reg;
    logic [TIME_W-1:0] t_reg;
    logic [MUL_W-1:0]  p1_reg;
    verdict_t          res_reg;

    // output register
    logic              out_valid_reg;
    logic [1:0]        verdict_reg;

    // decisions
    logic calib_end;
    logic below;
    logic dur_short;
    logic room;
    logic out_free;

    // serial units
    logic               mul_start;
    logic [MUL_W-1:0]   mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic               mul_done;
    logic [MUL_W-1:0]   mul_product;
    logic               div_start;
    logic               div_done;
    logic [DIST_W-1:0]  div_quotient;

    assign calib_sum_next  = calib_sum_reg + CSUM_W'(d_reg);
    assign calib_seen_next = calib_seen_reg + CAL_W'(1);
    // a wrap to zero means 1024 samples were seen
    assign calib_end       = (calib_seen_next == '0) || (calib_seen_next >= calib_count_reg);

    // d < baseline - offset, done without going negative
    assign below     = ({1'b0, d_reg} + {1'b0, dip_offset_reg}) < {1'b0, baseline_reg};
    assign dur_short = (t_reg - dip_start_reg) < min_dur_reg;
    assign room      = dip_samples_reg < DIP_CNT_W'(DIP_BUFFER_DEPTH);
    assign out_free  = !out_valid_reg || out_ready;

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_count_reg <= CALIB_COUNT_RST;
            dip_offset_reg  <= DIP_OFFSET_RST;
            min_dur_reg     <= MIN_DUR_RST;
            var_limit_reg   <= VAR_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CALIB_COUNT: calib_count_reg <= cfg_data[CAL_W-1:0];
                CFG_DIP_OFFSET:  dip_offset_reg  <= cfg_data[OFFSET_W-1:0];
                CFG_MIN_DUR:     min_dur_reg     <= cfg_data[TIME_W-1:0];
                CFG_VAR_LIMIT:   var_limit_reg   <= cfg_data[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (!calibrated_reg)
                begin
                    state_next = (calib_end && calib_seen_next != '0) ? ST_DIV : ST_DONE;
                end
                else if (below)
                begin
                    state_next = (!dip_active_reg || room) ? ST_SQ : ST_DONE;
                end
                else if (dip_active_reg && !dur_short)
                begin
                    state_next = ST_NQ;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV:  if (div_done) state_next = ST_DONE;
            ST_SQ:   if (mul_done) state_next = ST_DONE;
            ST_NQ:   if (mul_done) state_next = ST_SS;
            ST_SS:   if (mul_done) state_next = ST_LN;
            ST_LN:   if (mul_done) state_next = ST_LNN;
            ST_LNN:  if (mul_done) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // sequencer: unit starts and operand selection
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_EVAL:
            begin
                if (!calibrated_reg)
                begin
                    div_start = calib_end && (calib_seen_next != '0);
                end
                else if (below)
                begin
                    // square of the new sample
                    mul_start = !dip_active_reg || room;
                    mul_a     = MUL_W'(d_reg);
                    mul_b     = MUL_B_W'(d_reg);
                end
                else
                begin
                    // n * Q
                    mul_start = dip_active_reg && !dur_short;
                    mul_a     = MUL_W'(dip_sq_reg);
                    mul_b     = MUL_B_W'(dip_samples_reg);
                end
            end
            ST_NQ:
            begin
                // S * S
                mul_start = mul_done;
                mul_a     = MUL_W'(dip_sum_reg);
                mul_b     = dip_sum_reg;
            end
            ST_SS:
            begin
                // limit * n
                mul_start = mul_done;
                mul_a     = MUL_W'(var_limit_reg);
                mul_b     = MUL_B_W'(dip_samples_reg);
            end
            ST_LN:
            begin
                // (limit * n) * n
                mul_start = mul_done;
                mul_a     = mul_product;
                mul_b     = MUL_B_W'(dip_samples_reg);
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // architectural state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calibrated_reg  <= 1'b0;
            calib_sum_reg   <= '0;
            calib_seen_reg  <= '0;
            baseline_reg    <= '0;
            dip_active_reg  <= 1'b0;
            dip_samples_reg <= '0;
            dip_start_reg   <= '0;
            dip_sum_reg     <= '0;
            dip_sq_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                ST_EVAL:
                begin
                    if (!calibrated_reg)
                    begin
                        calib_sum_reg  <= calib_sum_next;
                        calib_seen_reg <= calib_seen_next;
                        if (calib_end)
                        begin
                            calibrated_reg <= 1'b1;
                            if (calib_seen_next == '0)
                            begin
                                baseline_reg <= '0;
                            end
                        end
                    end
                    else if (below)
                    begin
                        if (!dip_active_reg)
                        begin
                            // open a dip; the square is added in ST_SQ
                            dip_active_reg  <= 1'b1;
                            dip_start_reg   <= t_reg;
                            dip_samples_reg <= DIP_CNT_W'(1);
                            dip_sum_reg     <= SUM_W'(d_reg);
                            dip_sq_reg      <= '0;
                        end
                        else if (room)
                        begin
                            dip_samples_reg <= dip_samples_reg + DIP_CNT_W'(1);
                            dip_sum_reg     <= dip_sum_reg + SUM_W'(d_reg);
                        end
                        else
                        begin
                            // buffer full: drop the dip without a verdict
                            dip_active_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        dip_active_reg <= 1'b0;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        baseline_reg <= div_quotient;
                    end
                end
                ST_SQ:
                begin
                    if (mul_done)
                    begin
                        dip_sq_reg <= dip_sq_reg + mul_product[SQ_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // working registers (no reset needed)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    d_reg <= distance;
                    t_reg <= time_ms;
                end
            end
            ST_EVAL:
            begin
                res_reg <= calibrated_reg ? VERDICT_NONE : VERDICT_CALIBRATING;
            end
            ST_NQ:
            begin
                if (mul_done)
                begin
                    p1_reg <= mul_product;
                end
            end
            ST_SS:
            begin
                // n*Q - S*S, never negative
                if (mul_done)
                begin
                    p1_reg <= p1_reg - mul_product;
                end
            end
            ST_LNN:
            begin
                if (mul_done)
                begin
                    res_reg <= (p1_reg <= mul_product) ? VERDICT_VEHICLE : VERDICT_OTHER;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            verdict_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

    // ------------------------------------------------------------------
    // serial units
    // ------------------------------------------------------------------
    rdvc_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    rdvc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (calib_sum_next),
        .divisor  (calib_seen_next),
        .done     (div_done),
        .quotient (div_quotient)
    );

`ifndef SYNTHESIS
    a_dip_after_calib: assert property (@(posedge clk) disable iff (!rst_n)
        dip_active_reg |-> calibrated_reg)
        else $error("dip open before calibration finished");

    a_dip_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        dip_active_reg |-> (dip_samples_reg != '0 &&
                            dip_samples_reg <= DIP_CNT_W'(DIP_BUFFER_DEPTH)))
        else $error("dip sample count out of range");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside its state");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("result not loaded on completion");
`endif

endmodule

// File: sv/rdvc_mul.sv
// ----------------------------------------------------------------------------
// rdvc_mul
// Shift-add multiplier, one multiplier bit per cycle, stops when the
// remaining multiplier bits are all zero.
// ----------------------------------------------------------------------------
module rdvc_mul
    import rdvc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MUL_W-1:0]   a,
    input  logic [MUL_B_W-1:0] b,
    output logic               done,
    output logic [MUL_W-1:0]   product
);

    logic               run_reg;
    logic [MUL_W-1:0]   a_reg;
    logic [MUL_B_W-1:0] b_reg;
    logic [MUL_W-1:0]   acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
        end
        else if (run_reg && b_reg == '0)
        begin
            run_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (run_reg && b_reg != '0)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= {a_reg[MUL_W-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[MUL_B_W-1:1]};
        end
    end

    assign done    = run_reg && (b_reg == '0);
    assign product = acc_reg;

endmodule

// File: sv/rdvc_div.sv
// ----------------------------------------------------------------------------
// rdvc_div
// Restoring divider for the baseline average, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rdvc_div
    import rdvc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [CSUM_W-1:0] dividend,
    input  logic [CAL_W-1:0]  divisor,
    output logic              done,
    output logic [DIST_W-1:0] quotient
);

    logic                 run_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [CAL_W-1:0]     rem_reg;
    logic [CSUM_W-1:0]    quo_reg;
    logic [CAL_W-1:0]     divisor_reg;
    logic [CAL_W:0]       trial;
    logic [CAL_W:0]       trial_sub;
    logic                 fits;

    assign trial     = {rem_reg, quo_reg[CSUM_W-1]};
    assign trial_sub = trial - {1'b0, divisor_reg};
    assign fits      = trial >= {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
        end
        else if (done)
        begin
            run_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cnt_reg     <= '0;
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= divisor;
        end
        else if (run_reg && !done)
        begin
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
            rem_reg <= fits ? trial_sub[CAL_W-1:0] : trial[CAL_W-1:0];
            quo_reg <= {quo_reg[CSUM_W-2:0], fits};
        end
    end

    assign done     = run_reg && (cnt_reg == DIV_CNT_W'(DIV_STEPS));
    // an average of 16-bit samples always fits 16 bits
    assign quotient = quo_reg[DIST_W-1:0];

endmodule
